### design/extended_gcd_top_assert.svh
// ----------------------------------------------------------------------------
// Extended GCD assertion macros
// Shared concurrent-assertion forms for the extended GCD checker.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_GCD_TOP_ASSERT_SVH
`define EXTENDED_GCD_TOP_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define EGCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define EGCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/egcd_pkg.sv
// ----------------------------------------------------------------------------
// Extended GCD package
// Shared constants, sequencer states and control structs.
// ----------------------------------------------------------------------------
package egcd_pkg;

   localparam int OPERAND_WIDTH_DEF = 31;
   localparam int COEFF_WIDTH       = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic load;    // capture operands, seed coefficients
      logic init;    // open a round: clear remainder and products
      logic step;    // one quotient bit
      logic update;  // close a round: rotate remainders and coefficients
   } ctrl_type;

   typedef struct packed {
      logic b_zero;
   } status_type;

endpackage

### design/egcd_datapath.sv
// ----------------------------------------------------------------------------
// Extended GCD datapath
// Shared shift-subtract divider with coefficient multiply-accumulate.
// ----------------------------------------------------------------------------
module egcd_datapath
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic                       clock,
   input  ctrl_type                   ctrl,
   input  logic [OPERAND_WIDTH-1:0]   operand_a,
   input  logic [OPERAND_WIDTH-1:0]   operand_b,
   output status_type                 status,
   output logic [OPERAND_WIDTH-1:0]   divisor_gcd,
   output logic [COEFF_WIDTH-1:0]     coeff_x,
   output logic [COEFF_WIDTH-1:0]     coeff_y
);

   logic [OPERAND_WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [OPERAND_WIDTH-1:0] part_ff, part_in, shift_ff, shift_in;
   logic [COEFF_WIDTH-1:0]   xp_ff, xp_in, xc_ff, xc_in;
   logic [COEFF_WIDTH-1:0]   yp_ff, yp_in, yc_ff, yc_in;
   logic [COEFF_WIDTH-1:0]   qx_ff, qx_in, qy_ff, qy_in;

   logic [OPERAND_WIDTH:0]   trial;
   logic [OPERAND_WIDTH:0]   diff;
   logic                     fits;

   // Bring down the next dividend bit and trial-subtract the divisor
   assign trial = {part_ff, shift_ff[OPERAND_WIDTH-1]};
   assign fits  = (trial >= {1'b0, b_ff});
   assign diff  = trial - {1'b0, b_ff};

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      part_in  = part_ff;
      shift_in = shift_ff;
      xp_in    = xp_ff;
      xc_in    = xc_ff;
      yp_in    = yp_ff;
      yc_in    = yc_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      if (ctrl.load) begin
         a_in  = operand_a;
         b_in  = operand_b;
         xp_in = COEFF_WIDTH'(1);
         xc_in = '0;
         yp_in = '0;
         yc_in = COEFF_WIDTH'(1);
      end
      if (ctrl.init) begin
         part_in  = '0;
         shift_in = a_ff;
         qx_in    = '0;
         qy_in    = '0;
      end
      if (ctrl.step) begin
         part_in  = fits ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
         shift_in = {shift_ff[OPERAND_WIDTH-2:0], 1'b0};
         // Horner form of q*xc and q*yc, quotient bits MSB first
         qx_in    = {qx_ff[COEFF_WIDTH-2:0], 1'b0} + (fits ? xc_ff : '0);
         qy_in    = {qy_ff[COEFF_WIDTH-2:0], 1'b0} + (fits ? yc_ff : '0);
      end
      if (ctrl.update) begin
         a_in  = b_ff;
         b_in  = part_ff;
         xp_in = xc_ff;
         xc_in = xp_ff - qx_ff;
         yp_in = yc_ff;
         yc_in = yp_ff - qy_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      part_ff  <= part_in;
      shift_ff <= shift_in;
      xp_ff    <= xp_in;
      xc_ff    <= xc_in;
      yp_ff    <= yp_in;
      yc_ff    <= yc_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
   end

   assign status.b_zero = (b_ff == '0);
   assign divisor_gcd   = a_ff;
   assign coeff_x       = xp_ff;
   assign coeff_y       = yp_ff;

endmodule

### design/egcd_sequencer.sv
// ----------------------------------------------------------------------------
// Extended GCD sequencer
// Steps the shared divider through the rounds of one item.
// ----------------------------------------------------------------------------
module egcd_sequencer
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output ctrl_type   ctrl,
   output logic       busy,
   output logic       rsp_valid
);

   localparam int CNT_W = $clog2(OPERAND_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_CHECK;
         ST_CHECK:  state_in = status.b_zero ? ST_DONE : ST_DIVIDE;
         ST_DIVIDE: if (count_ff == '0) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_CHECK;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctrl      = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      count_in  = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         ST_CHECK: begin
            ctrl.init = 1'b1;
            count_in  = CNT_LAST;
         end
         ST_DIVIDE: begin
            ctrl.step = 1'b1;
            count_in  = count_ff - CNT_W'(1);
         end
         ST_UPDATE: begin
            ctrl.update = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/extended_gcd_top.sv
// ----------------------------------------------------------------------------
// Extended GCD top level
// Rounds: R remainder rounds run from the start transfer to the result
//   strobe (none when operand b is zero, up to about 46 at 31 bits).
// Items: one at a time; busy stays high through the result strobe, and the
//   single shared divider resolves one quotient bit per cycle.
// Reset: synchronous, active high; returns to idle, no result pending.
// ----------------------------------------------------------------------------
module extended_gcd_top
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Command channel: transfer on start while not busy
   input  logic                           start,
   output logic                           busy,
   input  logic [OPERAND_WIDTH-1:0]       req_operand_a,
   input  logic [OPERAND_WIDTH-1:0]       req_operand_b,
   // Result channel: one-cycle strobe, receiver cannot stall
   output logic                           rsp_valid,
   output logic [OPERAND_WIDTH-1:0]       rsp_divisor_gcd,
   output logic signed [COEFF_WIDTH-1:0]  rsp_coeff_x,
   output logic signed [COEFF_WIDTH-1:0]  rsp_coeff_y
);

   ctrl_type                 ctrl;
   status_type               status;
   logic [COEFF_WIDTH-1:0]   coeff_x;
   logic [COEFF_WIDTH-1:0]   coeff_y;

   // Sequencer: per round, a CHECK state (open round or finish when the
   // divisor is zero), then DIVIDE for every quotient bit, then UPDATE.
   egcd_sequencer #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath: restoring divider producing quotient bits MSB first, with
   // q*x and q*y accumulated alongside so no multiplier is needed.
   // Coefficients wrap modulo 2^32, matching the truncated result.
   egcd_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .ctrl        (ctrl),
      .operand_a   (req_operand_a),
      .operand_b   (req_operand_b),
      .status      (status),
      .divisor_gcd (rsp_divisor_gcd),
      .coeff_x     (coeff_x),
      .coeff_y     (coeff_y)
   );

   // Hold results in the datapath registers; present them signed
   assign rsp_coeff_x = $signed(coeff_x);
   assign rsp_coeff_y = $signed(coeff_y);

endmodule

### design/egcd_checker.sv
// ----------------------------------------------------------------------------
// Extended GCD checker
// Port-level temporal checks on the extended GCD top level.
// ----------------------------------------------------------------------------
`include "extended_gcd_top_assert.svh"

module egcd_checker
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [OPERAND_WIDTH-1:0]       rsp_divisor_gcd,
   input logic signed [COEFF_WIDTH-1:0]  rsp_coeff_x,
   input logic signed [COEFF_WIDTH-1:0]  rsp_coeff_y
);

   `EGCD_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy, "accepted item not busy")
   `EGCD_ASSERT(a_rsp_pulse, clock, reset, rsp_valid |=> (!rsp_valid && !busy), "result not a single pulse")
   `EGCD_ASSERT(a_rsp_after_work, clock, reset, !busy |=> !rsp_valid, "result without work")
   `EGCD_ASSERT(a_zero_gcd, clock, reset, (rsp_valid && rsp_divisor_gcd == '0) |-> (rsp_coeff_x == 1 && rsp_coeff_y == 0), "zero gcd with wrong coefficients")
   `EGCD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid), "not idle after reset")

endmodule

bind extended_gcd_top egcd_checker #(
   .OPERAND_WIDTH (OPERAND_WIDTH)
) u_egcd_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_divisor_gcd (rsp_divisor_gcd),
   .rsp_coeff_x     (rsp_coeff_x),
   .rsp_coeff_y     (rsp_coeff_y)
);

### test/tb_extended_gcd_top.sv
// ----------------------------------------------------------------------------
// Extended GCD testbench
// Sends operand pairs over the start/busy command port and compares each
// result strobe against an in-bench extended Euclid calculation: gcd first,
// then both Bezout coefficients. Directed corner pairs come first, then
// random pairs with shared factors, Fibonacci neighbors and mixed sizes.
// ----------------------------------------------------------------------------
module tb_extended_gcd_top
   import egcd_pkg::*;
();

   localparam int OPW           = OPERAND_WIDTH_DEF;
   localparam int RANDOM_PAIRS  = 400;
   localparam int IDLE_PERCENT  = 38;
   localparam int STALL_LIMIT   = 20000;  // cycles with no transfer on either side
   localparam int SETTLE_CYCLES = 1600;   // at least one worst-case item latency

   typedef logic [OPW-1:0] operand_type;

   typedef struct {
      operand_type a;
      operand_type b;
      bit          drain;  // hold this pair until every result is back
   } operand_pair_type;

   typedef struct {
      operand_type                   divisor;
      logic signed [COEFF_WIDTH-1:0] coeff_x;
      logic signed [COEFF_WIDTH-1:0] coeff_y;
   } bezout_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   operand_type req_operand_a = '0;
   operand_type req_operand_b = '0;

   logic                          busy;
   logic                          rsp_valid;
   operand_type                   rsp_divisor_gcd;
   logic signed [COEFF_WIDTH-1:0] rsp_coeff_x;
   logic signed [COEFF_WIDTH-1:0] rsp_coeff_y;

   operand_pair_type operand_queue[$];   // pairs waiting for a start transfer
   bezout_type       gcd_expected[$];    // results owed by the block, oldest first
   operand_type      fib [0:46];
   int               sent_count  = 0;
   int               error_count = 0;
   int               idle_cycles = 0;

   extended_gcd_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .rsp_valid       (rsp_valid),
      .rsp_divisor_gcd (rsp_divisor_gcd),
      .rsp_coeff_x     (rsp_coeff_x),
      .rsp_coeff_y     (rsp_coeff_y)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Iterative extended Euclid with truncating division. Coefficients run
   // modulo 2^64 and are cut to the coefficient width at the end; a zero
   // second operand skips the loop and leaves (a, 1, 0).
   function automatic bezout_type bezout_predict(input operand_type a_in,
                                                 input operand_type b_in);
      bit [63:0]  a, b, q, r, xp, xc, yp, yc, xn, yn;
      bezout_type res;
      a  = 64'(a_in);
      b  = 64'(b_in);
      xp = 64'd1;
      xc = 64'd0;
      yp = 64'd0;
      yc = 64'd1;
      while (b != 0) begin
         q  = a / b;
         r  = a - q * b;
         xn = xp - q * xc;
         yn = yp - q * yc;
         a  = b;
         b  = r;
         xp = xc;
         xc = xn;
         yp = yc;
         yc = yn;
      end
      res.divisor = a[OPW-1:0];
      res.coeff_x = xp[COEFF_WIDTH-1:0];
      res.coeff_y = yp[COEFF_WIDTH-1:0];
      return res;
   endfunction

   // Mix of zero, near-max, small and random-size operands; full-width draws
   // dominate so that every operand bit sees both values.
   function automatic operand_type random_operand();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0)
         return '0;
      else if (sel == 1)
         return ~(operand_type'(1) << $urandom_range(0, OPW - 1));
      else if (sel <= 4)
         return operand_type'($urandom_range(1, 255));
      else if (sel <= 9)
         return operand_type'($urandom >> $urandom_range(1, 30));
      else
         return operand_type'($urandom);
   endfunction

   task automatic queue_pair(input operand_type a, input operand_type b,
                             input bit drain = 1'b0);
      operand_pair_type p;
      p.a     = a;
      p.b     = b;
      p.drain = drain;
      operand_queue.insert(operand_queue.size(), p);
   endtask

   // Driver: retire the pair on a start transfer, then present the next one
   // unless the queue is empty, a drain is pending or this cycle idles.
   // Idling stops entirely for a stretch in the middle of the random part.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            gcd_expected.insert(gcd_expected.size(),
                                bezout_predict(req_operand_a, req_operand_b));
            void'(operand_queue.pop_front());
            sent_count++;
         end
         if (operand_queue.size() == 0 ||
             (operand_queue[0].drain && gcd_expected.size() != 0) ||
             (!(sent_count >= 150 && sent_count < 260) &&
              $urandom_range(0, 99) < IDLE_PERCENT)) begin
            start <= 1'b0;
         end else begin
            start         <= 1'b1;
            req_operand_a <= operand_queue[0].a;
            req_operand_b <= operand_queue[0].b;
         end
      end
   end

   // Monitor: each strobe retires the oldest expectation, field by field.
   always @(posedge clock) begin
      bezout_type exp_res;
      if (!reset && rsp_valid) begin
         if (gcd_expected.size() == 0) begin
            $display("%0t: unexpected result: expected none, got gcd %0d x %0d y %0d",
                     $time, rsp_divisor_gcd, rsp_coeff_x, rsp_coeff_y);
            error_count++;
         end else begin
            exp_res = gcd_expected.pop_front();
            if (rsp_divisor_gcd !== exp_res.divisor) begin
               $display("%0t: gcd mismatch: expected %0d, got %0d",
                        $time, exp_res.divisor, rsp_divisor_gcd);
               error_count++;
            end
            if (rsp_coeff_x !== exp_res.coeff_x) begin
               $display("%0t: coeff_x mismatch: expected %0d, got %0d",
                        $time, exp_res.coeff_x, rsp_coeff_x);
               error_count++;
            end
            if (rsp_coeff_y !== exp_res.coeff_y) begin
               $display("%0t: coeff_y mismatch: expected %0d, got %0d",
                        $time, exp_res.coeff_y, rsp_coeff_y);
               error_count++;
            end
         end
      end
   end

   // Watchdog: drop the run when neither side transfers for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      operand_type max_op;
      operand_type a, b, d;
      int          k;
      max_op = '1;
      fib[0] = '0;
      fib[1] = operand_type'(1);
      for (int i = 2; i <= 46; i++)
         fib[i] = fib[i-1] + fib[i-2];

      // Directed corners: zero operands, extremes, worst-case round count,
      // the swap when a < b, multiples and large common factors.
      queue_pair('0, '0);
      queue_pair(operand_type'(12345), '0);
      queue_pair(max_op, '0);
      queue_pair('0, operand_type'(1));
      queue_pair('0, max_op);
      queue_pair(operand_type'(1), operand_type'(1));
      queue_pair(max_op, max_op);
      queue_pair(max_op, operand_type'(1));
      queue_pair(operand_type'(1), max_op);
      queue_pair(max_op, max_op - 1);
      queue_pair(max_op - 1, max_op);
      queue_pair(fib[46], fib[45]);
      queue_pair(fib[45], fib[46]);
      queue_pair(operand_type'(12), operand_type'(18), 1'b1);
      queue_pair(operand_type'(240), operand_type'(46));
      queue_pair(operand_type'(46), operand_type'(240));
      queue_pair(operand_type'(1) << 30, operand_type'(1) << 20);
      queue_pair(operand_type'(3) << 29, operand_type'(1) << 29);
      queue_pair(operand_type'(999999937), operand_type'(3));
      queue_pair(max_op - 1, max_op >> 1);
      queue_pair(operand_type'(65536 * 17), operand_type'(65536 * 13));
      queue_pair(operand_type'(31'h2AAA_AAAA), operand_type'(31'h5555_5555));

      // Random pairs: independent draws, shared factors, Fibonacci
      // neighbors either way round, and equal or multiple operands.
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         case ($urandom_range(0, 9))
            6, 7: begin
               d = operand_type'($urandom_range(1, 65535));
               a = d * operand_type'($urandom_range(0, 32767));
               b = d * operand_type'($urandom_range(0, 32767));
            end
            8: begin
               k = $urandom_range(1, 45);
               a = fib[k+1];
               b = fib[k];
               if ($urandom_range(0, 1)) begin
                  a = fib[k];
                  b = fib[k+1];
               end
            end
            9: begin
               b = random_operand() >> $urandom_range(0, 16);
               a = b * operand_type'($urandom_range(1, 3));
               if ($urandom_range(0, 1)) begin
                  d = a;
                  a = b;
                  b = d;
               end
            end
            default: begin
               a = random_operand();
               b = random_operand();
            end
         endcase
         queue_pair(a, b, n == 300);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every pair to go out and every result to come back, then
      // give the block one more full latency to show any stray strobe.
      while (operand_queue.size() != 0 || gcd_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (gcd_expected.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, gcd_expected.size());
         error_count++;
      end
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/egcd_pkg.sv
design/egcd_datapath.sv
design/egcd_sequencer.sv
design/extended_gcd_top.sv
design/egcd_checker.sv
test/tb_extended_gcd_top.sv
